@@ hdl/srv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srv_pkg
// Shared widths, constants and types of the refraction pipeline.
// ----------------------------------------------------------------------------
package srv_pkg;
  localparam int FRAC      = 14;
  localparam int RFRAC     = 13;
  localparam int COMP_W    = 16;
  localparam int PERP_W    = 26;
  localparam int DIFF_W    = 54;
  localparam int ROOT_W    = 28;
  localparam int OUT_W     = 21;
  localparam int SQ_STEPS  = DIFF_W / 2;
  localparam int SQ_PER    = 3;
  localparam int SQ_STAGES = SQ_STEPS / SQ_PER;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PERP_W-1:0] perp_t;

  typedef struct packed {
    comp_t [2:0] n;
    perp_t [2:0] p;
  } carry_t;
endpackage
`default_nettype wire

@@ hdl/snell_refraction_vector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snell_refraction_vector
// Refracted direction by the vector form of Snell's law, fixed point.
//
//   channel  dir  payload
//   s_axis   in   incident xyz, normal xyz (Q2.14), index ratio (Q3.13)
//   m_axis   out  refracted xyz (Q7.14, saturated), clipped flag in tuser
//
// One item per cycle while the output is not stalled; 8 front stages, 9 square root
// stages (three root bits each), 2 back stages.
// Reset clears the valid bits only. A stalled output holds the whole
// pipeline, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module snell_refraction_vector (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z, index_ratio
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // refracted_x, refracted_y, refracted_z, one zero pad bit
  output logic [63:0]       m_axis_tdata,
  // clipped
  output logic              m_axis_tuser
);
  import srv_pkg::*;

  logic en;
  comp_t [2:0] a_in, n_in;
  logic f_valid, q_valid;
  logic [DIFF_W-1:0] diff;
  carry_t f_carry, q_carry;
  logic [ROOT_W-1:0] root;
  logic [3*OUT_W-1:0] result;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_in[i] = s_axis_tdata[16*i +: 16];
      n_in[i] = s_axis_tdata[48 + 16*i +: 16];
    end
  end

  srv_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_axis_tvalid && en),
    .a_in(a_in), .n_in(n_in), .ratio_in(s_axis_tdata[111:96]),
    .out_valid(f_valid), .diff(diff), .carry(f_carry)
  );

  srv_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f_valid), .diff(diff), .in_carry(f_carry),
    .out_valid(q_valid), .root(root), .out_carry(q_carry)
  );

  srv_back u_back (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(q_valid), .root(root), .carry(q_carry),
    .out_valid(m_axis_tvalid), .result(result), .clipped(m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, result};
endmodule
`default_nettype wire

@@ hdl/srv_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srv_front
// Cosine, perpendicular part and |1 - |perp|^2| over eight stages.
// ----------------------------------------------------------------------------
module srv_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire srv_pkg::comp_t [2:0]      a_in,
  input  wire srv_pkg::comp_t [2:0]      n_in,
  input  wire logic [15:0]               ratio_in,
  output logic                           out_valid,
  output logic [srv_pkg::DIFF_W-1:0]     diff,
  output srv_pkg::carry_t                carry
);
  import srv_pkg::*;

  localparam logic [DIFF_W-1:0] ONE_SQ = DIFF_W'(1) << (2 * FRAC);

  logic [7:1] v;
  comp_t a1 [3], a2 [3], a3 [3];
  comp_t n1 [3], n2 [3], n3 [3], n4 [3], n5 [3], n6 [3], n7 [3];
  logic [15:0] r1, r2, r3, r4;
  logic signed [31:0] pr1 [3];
  logic signed [18:0] cos2;
  logic signed [34:0] cn3 [3];
  logic signed [21:0] s4 [3];
  logic signed [38:0] m5 [3];
  perp_t p6 [3], p7 [3];
  logic [51:0] sq7 [3];

  logic signed [34:0] negdot;
  logic signed [20:0] cs;
  logic [DIFF_W-1:0] len2;

  always_comb begin
    negdot = -(35'(pr1[0]) + 35'(pr1[1]) + 35'(pr1[2]));
    cs = 21'((negdot + 35'sd8192) >>> FRAC);
    len2 = DIFF_W'(sq7[0]) + DIFF_W'(sq7[1]) + DIFF_W'(sq7[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v <= {v[6:1], in_valid};
      out_valid <= v[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1[i] <= a_in[i];
        n1[i] <= n_in[i];
        pr1[i] <= a_in[i] * n_in[i];
        a2[i] <= a1[i];
        n2[i] <= n1[i];
        a3[i] <= a2[i];
        n3[i] <= n2[i];
        cn3[i] <= cos2 * n2[i];
        n4[i] <= n3[i];
        s4[i] <= 22'(a3[i]) + 22'((cn3[i] + 35'sd8192) >>> FRAC);
        n5[i] <= n4[i];
        m5[i] <= $signed({1'b0, r4}) * s4[i];
        n6[i] <= n5[i];
        p6[i] <= PERP_W'((m5[i] + 39'sd4096) >>> RFRAC);
        n7[i] <= n6[i];
        p7[i] <= p6[i];
        sq7[i] <= 52'(p6[i]) * 52'(p6[i]);
        carry.n[i] <= n7[i];
        carry.p[i] <= p7[i];
      end
      r1 <= ratio_in;
      r2 <= r1;
      r3 <= r2;
      r4 <= r3;
      cos2 <= (cs > 21'sd16384) ? 19'sd16384 : 19'(cs);
      diff <= (len2 >= ONE_SQ) ? (len2 - ONE_SQ) : (ONE_SQ - len2);
    end
  end
endmodule
`default_nettype wire

@@ hdl/srv_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srv_sqrt
// Pipelined integer square root, three result bits per stage.
// ----------------------------------------------------------------------------
module srv_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [srv_pkg::DIFF_W-1:0] diff,
  input  wire srv_pkg::carry_t           in_carry,
  output logic                           out_valid,
  output logic [srv_pkg::ROOT_W-1:0]     root,
  output srv_pkg::carry_t                out_carry
);
  import srv_pkg::*;

  localparam int W = DIFF_W + 1;

  logic [W-1:0] rem [SQ_STAGES+1];
  logic [W-1:0] res [SQ_STAGES+1];
  logic         vv  [SQ_STAGES+1];
  carry_t       cc  [SQ_STAGES+1];

  assign rem[0] = W'(diff);
  assign res[0] = '0;
  assign vv[0]  = in_valid;
  assign cc[0]  = in_carry;

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
    logic [W-1:0] rn, sn;
    always_comb begin
      rn = rem[j];
      sn = res[j];
      for (int k = 0; k < SQ_PER; k++) begin
        if (rn >= sn + (W'(1) << (DIFF_W - 2 - 2 * (j * SQ_PER + k)))) begin
          rn = rn - (sn + (W'(1) << (DIFF_W - 2 - 2 * (j * SQ_PER + k))));
          sn = (sn >> 1) + (W'(1) << (DIFF_W - 2 - 2 * (j * SQ_PER + k)));
        end else begin
          sn = sn >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[j+1] <= 1'b0;
      end else if (en) begin
        vv[j+1] <= vv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= rn;
        res[j+1] <= sn;
        cc[j+1]  <= cc[j];
      end
    end
  end

  assign out_valid = vv[SQ_STAGES];
  assign root      = res[SQ_STAGES][ROOT_W-1:0];
  assign out_carry = cc[SQ_STAGES];
endmodule
`default_nettype wire

@@ hdl/srv_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srv_back
// Parallel part, final sum and saturation into the output register.
// ----------------------------------------------------------------------------
module srv_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [srv_pkg::ROOT_W-1:0] root,
  input  wire srv_pkg::carry_t           carry,
  output logic                           out_valid,
  output logic [3*srv_pkg::OUT_W-1:0]    result,
  output logic                           clipped
);
  import srv_pkg::*;

  localparam logic signed [30:0] OMAX = 31'sd1048575;
  localparam logic signed [30:0] OMIN = -31'sd1048576;

  logic v1;
  logic signed [44:0] pn1 [3];
  perp_t p1 [3];
  logic signed [30:0] r [3];
  logic [2:0] sat;
  logic [OUT_W-1:0] o [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r[i] = 31'(p1[i]) - 31'((pn1[i] + 45'sd8192) >>> FRAC);
      sat[i] = (r[i] > OMAX) || (r[i] < OMIN);
      if (r[i] > OMAX) begin
        o[i] = OMAX[OUT_W-1:0];
      end else if (r[i] < OMIN) begin
        o[i] = OMIN[OUT_W-1:0];
      end else begin
        o[i] = r[i][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pn1[i] <= $signed({1'b0, root}) * carry.n[i];
        p1[i]  <= carry.p[i];
      end
      result  <= {o[2], o[1], o[0]};
      clipped <= |sat;
    end
  end
endmodule
`default_nettype wire
